>>> hw/rtl/tfpc_pkg.sv
package tfpc_pkg;

  // field widths
  localparam int unsigned ActionW   = 2;
  localparam int unsigned TempW     = 8;
  localparam int unsigned DutyW     = 7;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  // default tick counter width
  localparam int unsigned TickCountBits = 8;

  // duty ramp: numerator is (t - ramp_start) * 100, one quotient bit per step
  localparam int unsigned NumW      = 15;
  localparam int unsigned DivCountW = 4;

  // item kinds
  localparam logic [ActionW-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ActionW-1:0] ACT_TICK   = 2'd1;
  localparam logic [ActionW-1:0] ACT_BUTTON = 2'd2;

  // modes
  localparam logic [ModeW-1:0] MODE_NORMAL    = 2'd0;
  localparam logic [ModeW-1:0] MODE_EMERGENCY = 2'd1;
  localparam logic [ModeW-1:0] MODE_ABNORMAL  = 2'd2;

  // register indexes
  localparam logic [CfgIndexW-1:0] REG_RAMP_START  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_RAMP_END    = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_EMERG_THR   = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_TICK_LIMIT  = 2'd3;

  // register reset values
  localparam logic [CfgDataW-1:0] RAMP_START_RST = 8'd20;
  localparam logic [CfgDataW-1:0] RAMP_END_RST   = 8'd40;
  localparam logic [CfgDataW-1:0] EMERG_THR_RST  = 8'd50;
  localparam logic [CfgDataW-1:0] TICK_LIMIT_RST = 8'd14;

  // status codes and full duty
  localparam logic [TempW-1:0] CODE_ABNORMAL = 8'hFE;
  localparam logic [TempW-1:0] CODE_SHUTDOWN = 8'hFF;
  localparam logic [DutyW-1:0] DUTY_FULL     = 7'd100;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic second;   // second result of a run is on the output
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // accepted item needs the duty ramp division
    logic has_res;   // accepted item gives at least one result
    logic two_res;   // accepted item gives two results
    logic div_done;  // division finishes at this edge
  } stat_t;

endpackage

>>> hw/rtl/thermal_fan_protection_controller.sv
// Fan protection controller: temperature samples, timer ticks and button presses
// come in on the input channel (action_i, temperature_i); status results go out
// on the output channel with the motor command, mode and watchdog request.
// Registers are written through the cfg channel (index 0 ramp start, 1 ramp end,
// 2 emergency threshold, 3 tick limit); cfg_ready_o is always high.
// One item is worked at a time. A sample outside the duty ramp, or a button press
// in the shutdown window, shows its result the cycle after the transfer. A sample
// inside the duty ramp runs a restoring divider, one quotient bit a cycle.
// A sample that moves emergency to abnormal gives two results back to back.
// Ticks, unused action codes and button presses outside the window give no result.
// When the receiver stalls the result holds and no new item is taken.
// Reset returns all registers to their defaults, the mode to normal and the
// motor to stopped; the block comes out of reset ready to take an item.
module thermal_fan_protection_controller #(
  parameter int unsigned TICK_COUNT_BITS = tfpc_pkg::TickCountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tfpc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tfpc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tfpc_pkg::ActionW-1:0]   action_i,
  input  logic [tfpc_pkg::TempW-1:0]     temperature_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tfpc_pkg::TempW-1:0]     status_byte_o,
  output logic                           motor_on_o,
  output logic [tfpc_pkg::DutyW-1:0]     motor_duty_o,
  output logic [tfpc_pkg::ModeW-1:0]     mode_o,
  output logic                           watchdog_request_o,
  output logic                           last_of_run_o
);

  tfpc_pkg::cmd_t  cmd;
  tfpc_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  tfpc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .last_of_run_o (last_of_run_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  tfpc_dp #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .action_i           (action_i),
    .temperature_i      (temperature_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .status_byte_o      (status_byte_o),
    .motor_on_o         (motor_on_o),
    .motor_duty_o       (motor_duty_o),
    .mode_o             (mode_o),
    .watchdog_request_o (watchdog_request_o)
  );

endmodule

>>> hw/rtl/tfpc_ctrl.sv
module tfpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             last_of_run_o,
  input  tfpc_pkg::stat_t  stat_i,
  output tfpc_pkg::cmd_t   cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT0 = 2'd2;
  localparam logic [1:0] ST_OUT1 = 2'd3;

  logic [1:0] state_q, state_d;
  logic       two_q, two_d;
  logic       in_xfer, out_xfer;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT0) || (state_q == ST_OUT1);
  assign out_xfer    = out_valid_o && out_ready_i;

  assign last_of_run_o = (state_q == ST_OUT1) || !two_q;
  assign cmd_o.accept  = in_xfer;
  assign cmd_o.second  = (state_q == ST_OUT1);

  // next state
  always_comb begin
    state_d = state_q;
    two_d   = two_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          two_d = stat_i.two_res;
          if (stat_i.need_div) begin
            state_d = ST_DIV;
          end else if (stat_i.has_res) begin
            state_d = ST_OUT0;
          end
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_OUT0;
        end
      end
      ST_OUT0: begin
        if (out_xfer) begin
          state_d = two_q ? ST_OUT1 : ST_IDLE;
        end
      end
      ST_OUT1: begin
        if (out_xfer) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      two_q   <= two_d;
    end
  end

endmodule

>>> hw/rtl/tfpc_dp.sv
module tfpc_dp #(
  parameter int unsigned TICK_COUNT_BITS = tfpc_pkg::TickCountBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [tfpc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [tfpc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [tfpc_pkg::ActionW-1:0]       action_i,
  input  logic [tfpc_pkg::TempW-1:0]         temperature_i,
  input  tfpc_pkg::cmd_t                     cmd_i,
  output tfpc_pkg::stat_t                    stat_o,
  output logic [tfpc_pkg::TempW-1:0]         status_byte_o,
  output logic                               motor_on_o,
  output logic [tfpc_pkg::DutyW-1:0]         motor_duty_o,
  output logic [tfpc_pkg::ModeW-1:0]         mode_o,
  output logic                               watchdog_request_o
);

  localparam int unsigned CmpW = (TICK_COUNT_BITS > tfpc_pkg::CfgDataW) ?
                                 TICK_COUNT_BITS : tfpc_pkg::CfgDataW;
  localparam logic [TICK_COUNT_BITS-1:0] TickMax = {TICK_COUNT_BITS{1'b1}};
  localparam logic [tfpc_pkg::DivCountW-1:0] DivSteps =
    tfpc_pkg::DivCountW'(tfpc_pkg::NumW);

  // configuration registers
  logic [tfpc_pkg::CfgDataW-1:0] ramp_start_q, ramp_end_q, emerg_thr_q, tick_limit_q;

  // block state
  logic [tfpc_pkg::ModeW-1:0]  mode_q, mode_d;
  logic [TICK_COUNT_BITS-1:0]  ticks_q, ticks_d;
  logic [tfpc_pkg::TempW-1:0]  last_temp_q, last_temp_d;
  logic                        motor_on_q, motor_on_d;
  logic [tfpc_pkg::DutyW-1:0]  duty_q, duty_d;
  logic                        wd_q, wd_d;
  logic [tfpc_pkg::TempW-1:0]  code_q, code_d;

  // divider
  logic                           busy_q;
  logic [tfpc_pkg::DivCountW-1:0] cnt_q;
  logic [tfpc_pkg::NumW-1:0]      num_q, num_step;
  logic [tfpc_pkg::TempW-1:0]     den_q, rem_q, rem_step;
  logic [tfpc_pkg::TempW:0]       rem_sh;
  logic                           qbit;
  logic [tfpc_pkg::TempW-1:0]     t_diff;
  logic [tfpc_pkg::NumW-1:0]      num_init;

  logic need_div, has_res, two_res, div_done;
  logic [CmpW-1:0] ticks_ext, limit_ext;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_start_q <= tfpc_pkg::RAMP_START_RST;
      ramp_end_q   <= tfpc_pkg::RAMP_END_RST;
      emerg_thr_q  <= tfpc_pkg::EMERG_THR_RST;
      tick_limit_q <= tfpc_pkg::TICK_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tfpc_pkg::REG_RAMP_START: ramp_start_q <= cfg_data_i;
        tfpc_pkg::REG_RAMP_END:   ramp_end_q   <= cfg_data_i;
        tfpc_pkg::REG_EMERG_THR:  emerg_thr_q  <= cfg_data_i;
        tfpc_pkg::REG_TICK_LIMIT: tick_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ticks_ext = CmpW'(ticks_q);
  assign limit_ext = CmpW'(tick_limit_q);

  // ramp numerator, valid only inside the ramp where t > ramp_start
  assign t_diff   = temperature_i - ramp_start_q;
  assign num_init = tfpc_pkg::NumW'(t_diff) * tfpc_pkg::NumW'(tfpc_pkg::DUTY_FULL);

  // one restoring division step
  assign rem_sh   = {rem_q, num_q[tfpc_pkg::NumW-1]};
  assign qbit     = (rem_sh >= {1'b0, den_q});
  assign rem_step = qbit ? tfpc_pkg::TempW'(rem_sh - {1'b0, den_q})
                         : tfpc_pkg::TempW'(rem_sh);
  assign num_step = {num_q[tfpc_pkg::NumW-2:0], qbit};
  assign div_done = busy_q && (cnt_q == tfpc_pkg::DivCountW'(1));

  // step decision on the accepted item
  always_comb begin
    mode_d      = mode_q;
    ticks_d     = ticks_q;
    last_temp_d = last_temp_q;
    motor_on_d  = motor_on_q;
    duty_d      = duty_q;
    wd_d        = wd_q;
    code_d      = code_q;
    need_div    = 1'b0;
    has_res     = 1'b0;
    two_res     = 1'b0;
    case (action_i)
      tfpc_pkg::ACT_SAMPLE: begin
        last_temp_d = temperature_i;
        code_d      = temperature_i;
        has_res     = 1'b1;
        case (mode_q)
          tfpc_pkg::MODE_NORMAL: begin
            if (temperature_i <= ramp_start_q) begin
              motor_on_d = 1'b0;
              duty_d     = '0;
            end else if (temperature_i < ramp_end_q) begin
              motor_on_d = 1'b1;
              need_div   = 1'b1;
            end else if (temperature_i <= emerg_thr_q) begin
              motor_on_d = 1'b1;
              duty_d     = tfpc_pkg::DUTY_FULL;
            end else begin
              mode_d = tfpc_pkg::MODE_EMERGENCY;
            end
          end
          tfpc_pkg::MODE_EMERGENCY: begin
            if (ticks_ext >= limit_ext) begin
              mode_d  = tfpc_pkg::MODE_ABNORMAL;
              two_res = 1'b1;
            end else begin
              if (temperature_i < emerg_thr_q) begin
                mode_d = tfpc_pkg::MODE_NORMAL;
              end
              motor_on_d = 1'b1;
              duty_d     = tfpc_pkg::DUTY_FULL;
            end
          end
          default: begin
            ticks_d    = '0;
            motor_on_d = 1'b1;
            duty_d     = tfpc_pkg::DUTY_FULL;
            wd_d       = 1'b1;
          end
        endcase
      end
      tfpc_pkg::ACT_TICK: begin
        if (mode_q == tfpc_pkg::MODE_EMERGENCY) begin
          if (ticks_q != TickMax) begin
            ticks_d = ticks_q + TICK_COUNT_BITS'(1);
          end
        end else begin
          ticks_d = '0;
        end
      end
      tfpc_pkg::ACT_BUTTON: begin
        code_d = tfpc_pkg::CODE_SHUTDOWN;
        if (last_temp_q >= ramp_end_q && last_temp_q <= emerg_thr_q) begin
          has_res = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tfpc_pkg::MODE_NORMAL;
      ticks_q     <= '0;
      last_temp_q <= '0;
      motor_on_q  <= 1'b0;
      duty_q      <= '0;
      wd_q        <= 1'b0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
    end else if (cmd_i.accept) begin
      mode_q      <= mode_d;
      ticks_q     <= ticks_d;
      last_temp_q <= last_temp_d;
      motor_on_q  <= motor_on_d;
      duty_q      <= duty_d;
      wd_q        <= wd_d;
      if (need_div) begin
        busy_q <= 1'b1;
        cnt_q  <= DivSteps;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q - tfpc_pkg::DivCountW'(1);
      if (div_done) begin
        busy_q <= 1'b0;
        duty_q <= tfpc_pkg::DutyW'(num_step);
      end
    end
  end

  // divider payload and result code
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      code_q <= code_d;
      num_q  <= num_init;
      den_q  <= ramp_end_q - ramp_start_q;
      rem_q  <= '0;
    end else if (busy_q) begin
      num_q <= num_step;
      rem_q <= rem_step;
    end
  end

  assign stat_o.need_div = need_div;
  assign stat_o.has_res  = has_res;
  assign stat_o.two_res  = two_res;
  assign stat_o.div_done = div_done;

  assign status_byte_o      = cmd_i.second ? tfpc_pkg::CODE_ABNORMAL : code_q;
  assign motor_on_o         = motor_on_q;
  assign motor_duty_o       = duty_q;
  assign mode_o             = mode_q;
  assign watchdog_request_o = wd_q;

endmodule

>>> hw/rtl/tfpc_checker.sv
module tfpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [tfpc_pkg::TempW-1:0]   status_byte_o,
  input logic [tfpc_pkg::DutyW-1:0]   motor_duty_o,
  input logic [tfpc_pkg::ModeW-1:0]   mode_o,
  input logic                         watchdog_request_o,
  input logic                         last_of_run_o
);

  // a result on the output holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_byte_o))
    else $error("stalled result changed");

  // no new item is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // a run of two results only happens on entry to abnormal mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> mode_o == tfpc_pkg::MODE_ABNORMAL)
    else $error("two results outside abnormal mode");

  // the first result of a pair is followed at once by the abnormal code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=>
      out_valid_o && last_of_run_o && status_byte_o == tfpc_pkg::CODE_ABNORMAL)
    else $error("abnormal code missing after first result");

  // watchdog request sticks and duty stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(watchdog_request_o) && (motor_duty_o <= tfpc_pkg::DUTY_FULL))
    else $error("watchdog request dropped or duty out of range");

endmodule

bind thermal_fan_protection_controller tfpc_checker u_tfpc_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tfpc_pkg::*;

  localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned HoldCycles   = 300;

  // one result as seen on the output channel
  typedef struct packed {
    logic [TempW-1:0] status;
    logic             motor_on;
    logic [DutyW-1:0] duty;
    logic [ModeW-1:0] mode;
    logic             wdog;
    logic             last;
  } fan_status_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic [CfgIndexW-1:0] cfg_index     = '0;
  logic [CfgDataW-1:0]  cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic [ActionW-1:0]   action        = '0;
  logic [TempW-1:0]     temperature   = '0;
  logic                 out_ready     = 1'b0;

  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [TempW-1:0]     status_byte_o;
  logic                 motor_on_o;
  logic [DutyW-1:0]     motor_duty_o;
  logic [ModeW-1:0]     mode_o;
  logic                 watchdog_request_o;
  logic                 last_of_run_o;

  // predicted registers and controller state
  logic [CfgDataW-1:0]      cfg_ramp_start = RAMP_START_RST;
  logic [CfgDataW-1:0]      cfg_ramp_end   = RAMP_END_RST;
  logic [CfgDataW-1:0]      cfg_threshold  = EMERG_THR_RST;
  logic [CfgDataW-1:0]      cfg_tick_limit = TICK_LIMIT_RST;
  logic [ModeW-1:0]         mdl_mode       = MODE_NORMAL;
  logic [TickCountBits-1:0] mdl_ticks      = '0;
  logic [TempW-1:0]         mdl_last_temp  = '0;
  logic                     mdl_motor_on   = 1'b0;
  logic [DutyW-1:0]         mdl_duty       = '0;
  logic                     mdl_wdog       = 1'b0;

  fan_status_t status_q[$];
  int unsigned error_count   = 0;
  bit          tx_steady     = 1'b0;
  bit          rx_steady     = 1'b0;
  bit          abnormal_ok   = 1'b0;
  int unsigned rx_hold       = 0;
  int unsigned rx_stall_left = 0;

  thermal_fan_protection_controller dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .action_i           (action),
    .temperature_i      (temperature),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .status_byte_o      (status_byte_o),
    .motor_on_o         (motor_on_o),
    .motor_duty_o       (motor_duty_o),
    .mode_o             (mode_o),
    .watchdog_request_o (watchdog_request_o),
    .last_of_run_o      (last_of_run_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic string status_str(fan_status_t s);
    return $sformatf("status %02h motor %0d duty %0d mode %0d wdog %0d last %0d",
                     s.status, s.motor_on, s.duty, s.mode, s.wdog, s.last);
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void expect_status(logic [TempW-1:0] code, logic last);
    status_q.push_back('{code, mdl_motor_on, mdl_duty, mdl_mode, mdl_wdog, last});
  endfunction

  // fan controller prediction for one accepted item
  function automatic void fan_model_step(logic [ActionW-1:0] act, logic [TempW-1:0] temp);
    bit to_abnormal;
    int ramp;
    to_abnormal = 1'b0;
    case (act)
      ACT_SAMPLE: begin
        mdl_last_temp = temp;
        case (mdl_mode)
          MODE_NORMAL: begin
            if (temp <= cfg_ramp_start) begin
              mdl_motor_on = 1'b0;
              mdl_duty     = '0;
            end else if (temp < cfg_ramp_end) begin
              // linear ramp between start and end
              ramp = ((int'(temp) - int'(cfg_ramp_start)) * int'(DUTY_FULL)) /
                     (int'(cfg_ramp_end) - int'(cfg_ramp_start));
              mdl_motor_on = 1'b1;
              mdl_duty     = ramp[DutyW-1:0];
            end else if (temp <= cfg_threshold) begin
              mdl_motor_on = 1'b1;
              mdl_duty     = DUTY_FULL;
            end else begin
              mdl_mode = MODE_EMERGENCY;
            end
          end
          MODE_EMERGENCY: begin
            if (mdl_ticks >= cfg_tick_limit) begin
              mdl_mode    = MODE_ABNORMAL;
              to_abnormal = 1'b1;
            end else begin
              if (temp < cfg_threshold) mdl_mode = MODE_NORMAL;
              mdl_motor_on = 1'b1;
              mdl_duty     = DUTY_FULL;
            end
          end
          default: begin
            mdl_ticks    = '0;
            mdl_motor_on = 1'b1;
            mdl_duty     = DUTY_FULL;
            mdl_wdog     = 1'b1;
          end
        endcase
        if (to_abnormal) begin
          expect_status(temp, 1'b0);
          expect_status(CODE_ABNORMAL, 1'b1);
        end else begin
          expect_status(temp, 1'b1);
        end
      end
      ACT_TICK: begin
        // ticks only count in emergency and saturate
        if (mdl_mode == MODE_EMERGENCY) begin
          if (mdl_ticks != '1) mdl_ticks = mdl_ticks + 1'b1;
        end else begin
          mdl_ticks = '0;
        end
      end
      ACT_BUTTON: begin
        if (mdl_last_temp >= cfg_ramp_end && mdl_last_temp <= cfg_threshold)
          expect_status(CODE_SHUTDOWN, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // temperatures cluster around the configured boundaries
  function automatic logic [TempW-1:0] pick_temperature();
    int base;
    logic [TempW-1:0] v;
    base = -1;
    case ($urandom_range(0, 5))
      0: base = int'(cfg_ramp_start);
      1: base = int'(cfg_ramp_end);
      2: base = int'(cfg_threshold);
      3: v = TempW'($urandom_range(int'(cfg_ramp_start), int'(cfg_ramp_end)));
      default: v = TempW'($urandom_range(0, 255));
    endcase
    if (base >= 0) begin
      base = base + int'($urandom_range(0, 6)) - 3;
      if (base < 0) base = 0;
      if (base > 255) base = 255;
      v = base[TempW-1:0];
    end
    return v;
  endfunction

  // random item, kept out of abnormal mode unless that is allowed
  function automatic void pick_item(output logic [ActionW-1:0] act,
                                    output logic [TempW-1:0] temp);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)      act = ACT_SAMPLE;
    else if (r < 80) act = ACT_TICK;
    else if (r < 97) act = ACT_BUTTON;
    else             act = ACT_UNUSED;
    temp = pick_temperature();
    if (!abnormal_ok) begin
      if (act == ACT_TICK && mdl_mode == MODE_EMERGENCY &&
          int'(mdl_ticks) + 1 >= int'(cfg_tick_limit))
        act = ACT_SAMPLE;
      if (act == ACT_SAMPLE && mdl_mode == MODE_NORMAL && temp > cfg_threshold &&
          int'(mdl_ticks) >= int'(cfg_tick_limit))
        temp = cfg_threshold;
    end
  endfunction

  // one input transfer; valid stays up when the next item follows at once
  task automatic send_item(input logic [ActionW-1:0] act, input logic [TempW-1:0] temp);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    action      <= act;
    temperature <= temp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    fan_model_step(act, temp);
  endtask

  // stop sending and let every predicted result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    for (int n = 0; n < DrainLimit && status_q.size() != 0; n++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_RAMP_START: cfg_ramp_start = val;
      REG_RAMP_END:   cfg_ramp_end   = val;
      REG_EMERG_THR:  cfg_threshold  = val;
      REG_TICK_LIMIT: cfg_tick_limit = val;
      default: ;
    endcase
  endtask

  // back to normal mode with a clear tick count unless already abnormal, then write all registers
  task automatic reconfigure(input logic [CfgDataW-1:0] start_v, input logic [CfgDataW-1:0] end_v,
                             input logic [CfgDataW-1:0] thr_v, input logic [CfgDataW-1:0] limit_v);
    if (mdl_mode == MODE_EMERGENCY) send_item(ACT_SAMPLE, '0);
    if (mdl_mode != MODE_ABNORMAL) send_item(ACT_TICK, '0);
    wait_idle();
    write_reg(REG_RAMP_START, start_v);
    write_reg(REG_RAMP_END, end_v);
    write_reg(REG_EMERG_THR, thr_v);
    write_reg(REG_TICK_LIMIT, limit_v);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    logic [ActionW-1:0] act;
    logic [TempW-1:0]   temp;
    for (int unsigned k = 0; k < count; k++) begin
      // switch between idling and full-rate stretches
      if (k % 64 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      pick_item(act, temp);
      send_item(act, temp);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // boundaries of the default ramp, the shutdown window and emergency entry/exit
  task automatic test_directed();
    send_item(ACT_SAMPLE, 8'd0);
    send_item(ACT_SAMPLE, 8'd20);
    send_item(ACT_SAMPLE, 8'd21);
    send_item(ACT_SAMPLE, 8'd39);
    send_item(ACT_SAMPLE, 8'd40);
    send_item(ACT_SAMPLE, 8'd50);
    send_item(ACT_BUTTON, 8'd0);
    send_item(ACT_SAMPLE, 8'd51);
    send_item(ACT_BUTTON, 8'd255);
    send_item(ACT_TICK, 8'd0);
    send_item(ACT_TICK, 8'd170);
    send_item(ACT_TICK, 8'd85);
    send_item(ACT_SAMPLE, 8'd60);
    send_item(ACT_SAMPLE, 8'd49);
    send_item(ACT_TICK, 8'd255);
    send_item(ACT_SAMPLE, 8'd255);
    send_item(ACT_SAMPLE, 8'd50);
    send_item(ACT_SAMPLE, 8'd10);
    send_item(ACT_SAMPLE, 8'd10);
    send_item(ACT_BUTTON, 8'd10);
    send_item(ACT_UNUSED, 8'd128);
    send_item(ACT_SAMPLE, 8'd30);
    send_item(ACT_BUTTON, 8'd30);
    send_item(ACT_SAMPLE, 8'd45);
    send_item(ACT_BUTTON, 8'd45);
  endtask

  task automatic test_default_ramp();
    run_random(300);
  endtask

  // full-span ramp, emergency out of reach
  task automatic test_wide_ramp();
    reconfigure(8'd0, 8'd255, 8'd255, 8'd255);
    run_random(250);
  endtask

  // ramp end not above ramp start
  task automatic test_degenerate_ramp();
    reconfigure(8'd100, 8'd60, 8'd150, 8'd3);
    run_random(200);
  endtask

  // registers at the opposite extremes
  task automatic test_register_extremes();
    reconfigure(8'd255, 8'd0, 8'd0, 8'd0);
    run_random(80);
  endtask

  task automatic test_random_settings();
    logic [CfgDataW-1:0] s, e, t, l;
    repeat (4) begin
      s = CfgDataW'($urandom_range(0, 150));
      e = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : s + 8'($urandom_range(1, 100));
      t = CfgDataW'($urandom_range(1, 255));
      l = CfgDataW'($urandom_range(1, 30));
      reconfigure(s, e, t, l);
      run_random(150);
    end
  endtask

  // receiver holds off while items keep coming, then the sender waits for the drain
  task automatic test_backpressure();
    logic [ActionW-1:0] act;
    logic [TempW-1:0]   temp;
    reconfigure(RAMP_START_RST, RAMP_END_RST, EMERG_THR_RST, TICK_LIMIT_RST);
    tx_steady = 1'b1;
    rx_hold   = HoldCycles;
    repeat (40) begin
      pick_item(act, temp);
      send_item(act, temp);
    end
    tx_steady = 1'b0;
    wait_idle();
    run_random(40);
  endtask

  // saturating tick count at the top limit, then the two-result move to abnormal
  task automatic test_abnormal_lockout();
    reconfigure(RAMP_START_RST, RAMP_END_RST, EMERG_THR_RST, 8'd255);
    send_item(ACT_SAMPLE, 8'd200);
    repeat (300) send_item(ACT_TICK, 8'($urandom_range(0, 255)));
    send_item(ACT_SAMPLE, 8'd100);
    abnormal_ok = 1'b1;
    run_random(100);
  endtask

  // receiver side: random stalls plus the long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_stall_left = rx_hold;
      rx_hold       = 0;
      out_ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_stall_left = idle_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    fan_status_t seen, want;
    if (rst_ni && out_valid_o && out_ready) begin
      seen = {status_byte_o, motor_on_o, motor_duty_o, mode_o, watchdog_request_o,
              last_of_run_o};
      if (status_q.size() == 0) begin
        note_failure($sformatf("result with none predicted: %s", status_str(seen)));
      end else begin
        want = status_q.pop_front();
        if (seen !== want)
          note_failure($sformatf("result mismatch: expected %s, got %s",
                                 status_str(want), status_str(seen)));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_ramp();
    test_wide_ramp();
    test_degenerate_ramp();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    test_abnormal_lockout();
    wait_idle();
    if (status_q.size() != 0)
      note_failure($sformatf("%0d predicted results never arrived", status_q.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
